>>> sv/rational_add_reduce_defines.svh
// Assertion macros used by the checker file of rational_add_reduce.
// Depends on nothing; the macros expect signals named clk and rst in scope.
`ifndef RATIONAL_ADD_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_REDUCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_add_reduce check failed");

// The consequent must hold in the cycle after the antecedent.
`define RAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_add_reduce check failed");

// Checked also while reset is high.
`define RAR_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rational_add_reduce check failed");

`endif

>>> sv/rar_pkg.sv
// Shared types and constants for the rational adder with reduction.
// Used by the controller, the datapath and the top level; depends on nothing.
package rar_pkg;

  localparam int VALUE_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int OP_BITS    = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
  localparam int PROD_W     = 2 * OP_BITS;
  localparam int NUM_W      = 33;
  localparam int DEN_W      = 32;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int K_W        = $clog2(NUM_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD_DEN,
    S_DIV_START,
    S_DIV_RUN,
    S_MUL_LCM,
    S_MUL_LEFT,
    S_MUL_RIGHT,
    S_GCD_SUM_INIT,
    S_GCD_SUM,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD_DEN,
    OP_GCD_SUM,
    OP_GCD_STEP,
    OP_GCD_SAVE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_MUL_LCM,
    OP_MUL_LEFT,
    OP_MUL_RIGHT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_LD_G,
    DIV_RD_G,
    DIV_SUM_R,
    DIV_LCM_R
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

>>> sv/rar_ctrl.sv
// Sequencer for the rational adder: walks the GCD, divide and multiply steps.
// Depends on rar_pkg; drives the datapath by command and reads its status.
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rar_pkg::dp_cmd_t  cmd,
  input  rar_pkg::dp_stat_t stat
);

  rar_pkg::state_t   state, state_next;
  rar_pkg::div_sel_t div_sel, div_sel_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rar_pkg::S_IDLE;
      div_sel   <= rar_pkg::DIV_LD_G;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_sel   <= div_sel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_sel_next   = div_sel;
    out_valid_next = out_valid && out_stall;
    cmd.op         = rar_pkg::OP_NOP;
    cmd.sel        = div_sel;
    in_stall       = (state != rar_pkg::S_IDLE);
    case (state)
      rar_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = rar_pkg::OP_LOAD;
          state_next = rar_pkg::S_CHECK;
        end
      end
      rar_pkg::S_CHECK: begin
        if (stat.bad) begin
          state_next = rar_pkg::S_EMIT;
        end else begin
          cmd.op     = rar_pkg::OP_GCD_DEN;
          state_next = rar_pkg::S_GCD_DEN;
        end
      end
      rar_pkg::S_GCD_DEN: begin
        if (stat.gcd_done) begin
          cmd.op       = rar_pkg::OP_GCD_SAVE;
          div_sel_next = rar_pkg::DIV_LD_G;
          state_next   = rar_pkg::S_DIV_START;
        end else begin
          cmd.op = rar_pkg::OP_GCD_STEP;
        end
      end
      rar_pkg::S_DIV_START: begin
        cmd.op     = rar_pkg::OP_DIV_START;
        state_next = rar_pkg::S_DIV_RUN;
      end
      rar_pkg::S_DIV_RUN: begin
        if (stat.div_done) begin
          cmd.op = rar_pkg::OP_DIV_SAVE;
          case (div_sel)
            rar_pkg::DIV_LD_G: begin
              div_sel_next = rar_pkg::DIV_RD_G;
              state_next   = rar_pkg::S_DIV_START;
            end
            rar_pkg::DIV_RD_G: begin
              state_next = rar_pkg::S_MUL_LCM;
            end
            rar_pkg::DIV_SUM_R: begin
              div_sel_next = rar_pkg::DIV_LCM_R;
              state_next   = rar_pkg::S_DIV_START;
            end
            default: begin
              state_next = rar_pkg::S_EMIT;
            end
          endcase
        end else begin
          cmd.op = rar_pkg::OP_DIV_STEP;
        end
      end
      rar_pkg::S_MUL_LCM: begin
        cmd.op     = rar_pkg::OP_MUL_LCM;
        state_next = rar_pkg::S_MUL_LEFT;
      end
      rar_pkg::S_MUL_LEFT: begin
        cmd.op     = rar_pkg::OP_MUL_LEFT;
        state_next = rar_pkg::S_MUL_RIGHT;
      end
      rar_pkg::S_MUL_RIGHT: begin
        cmd.op     = rar_pkg::OP_MUL_RIGHT;
        state_next = rar_pkg::S_GCD_SUM_INIT;
      end
      rar_pkg::S_GCD_SUM_INIT: begin
        cmd.op     = rar_pkg::OP_GCD_SUM;
        state_next = rar_pkg::S_GCD_SUM;
      end
      rar_pkg::S_GCD_SUM: begin
        if (stat.gcd_done) begin
          cmd.op       = rar_pkg::OP_GCD_SAVE;
          div_sel_next = rar_pkg::DIV_SUM_R;
          state_next   = rar_pkg::S_DIV_START;
        end else begin
          cmd.op = rar_pkg::OP_GCD_STEP;
        end
      end
      rar_pkg::S_EMIT: begin
        // The output register takes the result once it is empty or being drained.
        if (!out_valid || !out_stall) begin
          cmd.op         = rar_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = rar_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rar_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rar_dp.sv
// Datapath of the rational adder: binary GCD unit, radix-2 divider,
// shared multiplier and the output register. Depends on rar_pkg.
module rar_dp (
  input  logic                       clk,
  input  logic [rar_pkg::FIELD_W-1:0] left_num,
  input  logic [rar_pkg::FIELD_W-1:0] left_den,
  input  logic [rar_pkg::FIELD_W-1:0] right_num,
  input  logic [rar_pkg::FIELD_W-1:0] right_den,
  input  rar_pkg::dp_cmd_t           cmd,
  output rar_pkg::dp_stat_t          stat,
  output logic [rar_pkg::NUM_W-1:0]  sum_num,
  output logic [rar_pkg::DEN_W-1:0]  sum_den,
  output logic                       bad_input
);

  logic [rar_pkg::OP_BITS-1:0] ln, ld, rn, rd, a, b;
  logic                        bad;
  logic [rar_pkg::DEN_W-1:0]   lcm, res_den;
  logic [rar_pkg::NUM_W-1:0]   sum, res_num, g;
  logic [rar_pkg::NUM_W-1:0]   x, y;
  logic [rar_pkg::K_W-1:0]     k;
  logic [rar_pkg::NUM_W-1:0]   quo, rem, dvs;
  logic [rar_pkg::CNT_W-1:0]   cnt;

  // GCD step values
  logic [rar_pkg::NUM_W:0]     x_minus_y;
  logic [rar_pkg::NUM_W-1:0]   y_minus_x;
  logic [rar_pkg::NUM_W-1:0]   x_step, y_step;
  logic [rar_pkg::K_W-1:0]     k_step;
  logic [rar_pkg::NUM_W-1:0]   gcd_val;

  // Divider step values
  logic [rar_pkg::NUM_W:0]     trial, trial_diff;
  logic [rar_pkg::NUM_W-1:0]   dividend;

  // Shared multiplier
  logic [rar_pkg::OP_BITS-1:0] mul_l, mul_r;
  logic [rar_pkg::PROD_W-1:0]  prod;

  assign stat.bad      = bad;
  assign stat.gcd_done = (x == '0) || (y == '0);
  assign stat.div_done = (cnt == rar_pkg::CNT_W'(rar_pkg::NUM_W));

  always_comb begin
    x_minus_y = {1'b0, x} - {1'b0, y};
    y_minus_x = y - x;
    x_step    = x;
    y_step    = y;
    k_step    = k;
    if (!x[0] && !y[0]) begin
      x_step = x >> 1;
      y_step = y >> 1;
      k_step = k + 1'b1;
    end else if (!x[0]) begin
      x_step = x >> 1;
    end else if (!y[0]) begin
      y_step = y >> 1;
    end else if (!x_minus_y[rar_pkg::NUM_W]) begin
      x_step = x_minus_y[rar_pkg::NUM_W-1:0] >> 1;
    end else begin
      y_step = y_minus_x >> 1;
    end
    gcd_val = (x | y) << k;
  end

  always_comb begin
    trial      = {rem, quo[rar_pkg::NUM_W-1]};
    trial_diff = trial - {1'b0, dvs};
    case (cmd.sel)
      rar_pkg::DIV_LD_G:  dividend = rar_pkg::NUM_W'(ld);
      rar_pkg::DIV_RD_G:  dividend = rar_pkg::NUM_W'(rd);
      rar_pkg::DIV_SUM_R: dividend = sum;
      default:            dividend = rar_pkg::NUM_W'(lcm);
    endcase
  end

  always_comb begin
    case (cmd.op)
      rar_pkg::OP_MUL_LCM: begin
        mul_l = a;
        mul_r = rd;
      end
      rar_pkg::OP_MUL_LEFT: begin
        mul_l = ln;
        mul_r = b;
      end
      default: begin
        mul_l = rn;
        mul_r = a;
      end
    endcase
    prod = rar_pkg::PROD_W'(mul_l) * rar_pkg::PROD_W'(mul_r);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rar_pkg::OP_LOAD: begin
        ln  <= left_num[rar_pkg::OP_BITS-1:0];
        ld  <= left_den[rar_pkg::OP_BITS-1:0];
        rn  <= right_num[rar_pkg::OP_BITS-1:0];
        rd  <= right_den[rar_pkg::OP_BITS-1:0];
        bad <= (left_den[rar_pkg::OP_BITS-1:0] == '0) ||
               (right_den[rar_pkg::OP_BITS-1:0] == '0);
      end
      rar_pkg::OP_GCD_DEN: begin
        x <= rar_pkg::NUM_W'(ld);
        y <= rar_pkg::NUM_W'(rd);
        k <= '0;
      end
      rar_pkg::OP_GCD_SUM: begin
        x <= sum;
        y <= rar_pkg::NUM_W'(lcm);
        k <= '0;
      end
      rar_pkg::OP_GCD_STEP: begin
        x <= x_step;
        y <= y_step;
        k <= k_step;
      end
      rar_pkg::OP_GCD_SAVE: begin
        g <= gcd_val;
      end
      rar_pkg::OP_DIV_START: begin
        quo <= dividend;
        rem <= '0;
        dvs <= g;
        cnt <= '0;
      end
      rar_pkg::OP_DIV_STEP: begin
        // Dividend bits shift out the top while quotient bits shift in below.
        if (!trial_diff[rar_pkg::NUM_W]) begin
          rem <= trial_diff[rar_pkg::NUM_W-1:0];
          quo <= {quo[rar_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[rar_pkg::NUM_W-1:0];
          quo <= {quo[rar_pkg::NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      rar_pkg::OP_DIV_SAVE: begin
        case (cmd.sel)
          rar_pkg::DIV_LD_G:  a       <= quo[rar_pkg::OP_BITS-1:0];
          rar_pkg::DIV_RD_G:  b       <= quo[rar_pkg::OP_BITS-1:0];
          rar_pkg::DIV_SUM_R: res_num <= quo;
          default:            res_den <= quo[rar_pkg::DEN_W-1:0];
        endcase
      end
      rar_pkg::OP_MUL_LCM: begin
        lcm <= rar_pkg::DEN_W'(prod);
      end
      rar_pkg::OP_MUL_LEFT: begin
        sum <= rar_pkg::NUM_W'(prod);
      end
      rar_pkg::OP_MUL_RIGHT: begin
        sum <= sum + rar_pkg::NUM_W'(prod);
      end
      rar_pkg::OP_EMIT: begin
        sum_num   <= bad ? '0 : res_num;
        sum_den   <= bad ? '0 : res_den;
        bad_input <= bad;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/rational_add_reduce.sv
// Top level of the rational adder with GCD reduction.
// Depends on rar_pkg, rar_ctrl and rar_dp.
//
//   Channel  Direction  Handshake            Payload
//   in       inbound    in_valid / in_stall  left_num, left_den, right_num, right_den
//   out      outbound   out_valid/out_stall  sum_num, sum_den, bad_input
//
// One item is in flight at a time; after the transfer in, a result loads once
// four radix-2 divisions (each a start, 33 steps and a save) and the binary GCD
// steps on the two denominators and then on the sum have run, with the multiplies between.
// An item with a zero denominator skips all of that and goes from the check to the emit step.
// Reset (rst, synchronous) empties the output register and idles the sequencer.
// A result held by out_stall stalls only the next item's emit, not its transfer in.
module rational_add_reduce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rar_pkg::FIELD_W-1:0] left_num,
  input  logic [rar_pkg::FIELD_W-1:0] left_den,
  input  logic [rar_pkg::FIELD_W-1:0] right_num,
  input  logic [rar_pkg::FIELD_W-1:0] right_den,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rar_pkg::NUM_W-1:0]   sum_num,
  output logic [rar_pkg::DEN_W-1:0]   sum_den,
  output logic                        bad_input
);

  // Commands from the sequencer and status flags back from the datapath.
  rar_pkg::dp_cmd_t  cmd;
  rar_pkg::dp_stat_t stat;

  // The sequencer owns both handshakes: it takes an input transfer only when
  // idle, and it marks the output register full when the emit step runs.
  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath reduces ld and rd by their GCD, forms the common multiple
  // and the scaled sum, then divides both by their GCD.
  rar_dp u_dp (
    .clk       (clk),
    .left_num  (left_num),
    .left_den  (left_den),
    .right_num (right_num),
    .right_den (right_den),
    .cmd       (cmd),
    .stat      (stat),
    .sum_num   (sum_num),
    .sum_den   (sum_den),
    .bad_input (bad_input)
  );

endmodule

>>> sv/rar_checker.sv
// Port-level checks for rational_add_reduce and the bind that attaches them.
// Depends on rar_pkg and the macros in rational_add_reduce_defines.svh.
`include "rational_add_reduce_defines.svh"

module rar_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rar_pkg::NUM_W-1:0]   sum_num,
  input logic [rar_pkg::DEN_W-1:0]   sum_den,
  input logic                        bad_input
);

  // A result under stall stays offered.
  `RAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // An error result carries zero fields.
  `RAR_ASSERT_SAME(a_bad_zero, out_valid && bad_input, sum_num == '0 && sum_den == '0)
  // A good result always has a nonzero reduced denominator.
  `RAR_ASSERT_SAME(a_den_nonzero, out_valid && !bad_input, sum_den != '0)
  // An input transfer keeps the block busy for at least the next cycle.
  `RAR_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // Reset leaves the output register empty.
  `RAR_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid)

endmodule

bind rational_add_reduce rar_checker u_rar_checker (.*);
